/* rtl/kslwl_pkg.sv */
// Shared constants and types for the key sequence lock.
// No dependencies; used by every module in rtl/.
`default_nettype none

package kslwl_pkg;

   // default geometry
   localparam int NUM_KEYS_DEF    = 4;
   localparam int CODE_LENGTH_DEF = 4;

   // fixed register widths
   localparam int TICK_W    = 16;
   localparam int ROUNDS_W  = 4;
   localparam int CSR_IDX_W = 3;

   // register reset values
   localparam int CODE_RESET      = 216;
   localparam int LOCKOUT_RESET   = 1000;
   localparam int BLINK_ON_RESET  = 50;
   localparam int BLINK_OFF_RESET = 50;
   localparam int ROUNDS_RESET    = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_ON  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_OFF = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS    = 3'd4;

   // sequencer status towards the blink unit and the result register
   typedef struct packed {
      logic unlock;   // last key of the code matched this tick
      logic lockout;  // phase after this tick is lockout
   } lock_status_type;

endpackage

`default_nettype wire

/* rtl/kslwl_code_fsm.sv */
// Code matching sequencer: key position, discard count and lockout timer.
// Depends on kslwl_pkg.
`default_nettype none

module kslwl_code_fsm #(
   parameter int NUM_KEYS    = kslwl_pkg::NUM_KEYS_DEF,
   parameter int CODE_LENGTH = kslwl_pkg::CODE_LENGTH_DEF,
   localparam int KEY_W      = $clog2(NUM_KEYS),
   localparam int CODE_W     = CODE_LENGTH * KEY_W,
   localparam int PHASE_W    = $clog2(CODE_LENGTH + 2)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [NUM_KEYS-1:0]          key_mask,
   input  wire logic [CODE_W-1:0]            code_seq,
   input  wire logic [kslwl_pkg::TICK_W-1:0] lockout_ticks,
   output logic      [PHASE_W-1:0]           phase_in,
   output kslwl_pkg::lock_status_type        status
);

   localparam int POS_W  = $clog2(CODE_LENGTH);
   localparam int PAD_W  = 2 ** KEY_W;
   localparam logic [PHASE_W-1:0] PH_IDLE    = '0;
   localparam logic [PHASE_W-1:0] PH_LAST    = PHASE_W'(CODE_LENGTH - 1);
   localparam logic [PHASE_W-1:0] PH_DISCARD = PHASE_W'(CODE_LENGTH);
   localparam logic [PHASE_W-1:0] PH_LOCKOUT = PHASE_W'(CODE_LENGTH + 1);
   localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(CODE_LENGTH - 1);
   localparam logic [KEY_W:0]     KEY_LIMIT  = (KEY_W + 1)'(NUM_KEYS);

   logic [PHASE_W-1:0]           phase_ff;
   logic [POS_W-1:0]             discard_ff, discard_in;
   logic [kslwl_pkg::TICK_W-1:0] elapsed_ff, elapsed_in;

   logic [KEY_W-1:0] code_keys [CODE_LENGTH];
   logic [PAD_W-1:0] mask_pad;
   logic [POS_W-1:0] pos;
   logic [KEY_W-1:0] key;
   logic             press;
   logic             hit;
   logic             unlock;

   always_comb begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
         code_keys[i] = code_seq[i*KEY_W +: KEY_W];
      end
   end

   assign mask_pad = PAD_W'(key_mask);
   assign press    = |key_mask;
   assign pos      = phase_ff[POS_W-1:0];
   assign key      = code_keys[pos];
   assign hit      = ({1'b0, key} < KEY_LIMIT) && mask_pad[key];

   always_comb begin
      phase_in   = phase_ff;
      discard_in = discard_ff;
      elapsed_in = elapsed_ff;
      unlock     = 1'b0;
      if (phase_ff < PH_DISCARD) begin
         if (press) begin
            if (hit) begin
               if (phase_ff == PH_LAST) begin
                  unlock   = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
            end else if (phase_ff == PH_LAST) begin
               phase_in   = PH_LOCKOUT;
               elapsed_in = '0;
               discard_in = '0;
            end else begin
               // swallow the rest of a code length of presses
               discard_in = LAST_POS - pos;
               phase_in   = PH_DISCARD;
            end
         end
      end else if (phase_ff == PH_DISCARD) begin
         if (press) begin
            if (discard_ff <= POS_W'(1)) begin
               phase_in   = PH_LOCKOUT;
               elapsed_in = '0;
               discard_in = '0;
            end else begin
               discard_in = discard_ff - 1'b1;
            end
         end
      end else if (phase_ff == PH_LOCKOUT) begin
         // timer runs every tick, keys ignored
         if (elapsed_ff >= lockout_ticks) begin
            phase_in = PH_IDLE;
         end else begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end else begin
         phase_in = PH_IDLE;
      end
   end

   assign status.unlock  = unlock;
   assign status.lockout = (phase_in == PH_LOCKOUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         discard_ff <= '0;
         elapsed_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         discard_ff <= discard_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/kslwl_blink.sv */
// Success light blinker: on/off phases for a set number of rounds.
// Depends on kslwl_pkg.
`default_nettype none

module kslwl_blink (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire kslwl_pkg::lock_status_type     status,
   input  wire logic [kslwl_pkg::TICK_W-1:0]   on_ticks,
   input  wire logic [kslwl_pkg::TICK_W-1:0]   off_ticks,
   input  wire logic [kslwl_pkg::ROUNDS_W-1:0] rounds,
   output logic                                level_in
);

   logic                           active_ff, active_in;
   logic [kslwl_pkg::ROUNDS_W-1:0] rounds_left_ff, rounds_left_in;
   logic [kslwl_pkg::TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic                           level_ff;
   logic [kslwl_pkg::TICK_W-1:0]   len;

   assign len = level_ff ? on_ticks : off_ticks;

   always_comb begin
      active_in      = active_ff;
      rounds_left_in = rounds_left_ff;
      elapsed_in     = elapsed_ff;
      level_in       = level_ff;
      if (status.unlock) begin
         // (re)start from the first on phase
         active_in      = 1'b1;
         rounds_left_in = rounds;
         elapsed_in     = '0;
         level_in       = 1'b1;
      end else if (active_ff) begin
         if (elapsed_ff >= len) begin
            elapsed_in = '0;
            if (level_ff) begin
               level_in = 1'b0;
            end else if (rounds_left_ff == kslwl_pkg::ROUNDS_W'(1)) begin
               active_in      = 1'b0;
               rounds_left_in = '0;
               level_in       = 1'b0;
            end else begin
               rounds_left_in = rounds_left_ff - 1'b1;
               level_in       = 1'b1;
            end
         end else begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         rounds_left_ff <= '0;
         elapsed_ff     <= '0;
         level_ff       <= 1'b0;
      end else if (step) begin
         active_ff      <= active_in;
         rounds_left_ff <= rounds_left_in;
         elapsed_ff     <= elapsed_in;
         level_ff       <= level_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/key_sequence_lock_with_lockout.sv */
// Top level of the keypad combination lock: CSRs, request/result registers.
// Depends on kslwl_pkg, kslwl_code_fsm and kslwl_blink.
`default_nettype none

// Keypad combination lock with wrong-code lockout. Each request is one time
// tick carrying a mask of debounced key presses; each request yields exactly
// one response with the unlock pulse, lockout flag, success light level and
// the lock phase after that tick. A request is registered, then the whole
// state update runs combinationally into the response register, so the block
// takes one request every cycle; each response passes the request register
// and then the response register before it is presented.
// Throughput falls only when the response side stalls:
// the input register then holds one request and req_stall rises. CSRs
// (code, lockout length, blink on/off lengths, blink rounds) are written
// through csr_wr_en/csr_index/csr_wr_data and must only change while idle.
// The code holds CODE_LENGTH key numbers of clog2(NUM_KEYS) bits each, first
// key in the low bits; a key number not below NUM_KEYS never matches.
module key_sequence_lock_with_lockout #(
   parameter int NUM_KEYS    = kslwl_pkg::NUM_KEYS_DEF,
   parameter int CODE_LENGTH = kslwl_pkg::CODE_LENGTH_DEF,
   localparam int KEY_W      = $clog2(NUM_KEYS),
   localparam int CODE_W     = CODE_LENGTH * KEY_W,
   localparam int PHASE_W    = $clog2(CODE_LENGTH + 2),
   localparam int CSR_DATA_W = (CODE_W > kslwl_pkg::TICK_W) ? CODE_W : kslwl_pkg::TICK_W
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [NUM_KEYS-1:0]             req_key_pressed_mask,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_unlock_pulse,
   output logic                                 rsp_error_indicator,
   output logic                                 rsp_success_indicator,
   output logic [PHASE_W-1:0]                   rsp_lock_phase,
   // configuration
   input  wire logic                            csr_wr_en,
   input  wire logic [kslwl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]           csr_wr_data
);

   localparam logic [PHASE_W-1:0] PH_IDLE    = '0;
   localparam logic [PHASE_W-1:0] PH_LOCKOUT = PHASE_W'(CODE_LENGTH + 1);

   // ---- CSRs ----
   logic [CODE_W-1:0]                code_ff;
   logic [kslwl_pkg::TICK_W-1:0]     lockout_ff;
   logic [kslwl_pkg::TICK_W-1:0]     blink_on_ff;
   logic [kslwl_pkg::TICK_W-1:0]     blink_off_ff;
   logic [kslwl_pkg::ROUNDS_W-1:0]   rounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= CODE_W'(kslwl_pkg::CODE_RESET);
         lockout_ff   <= kslwl_pkg::TICK_W'(kslwl_pkg::LOCKOUT_RESET);
         blink_on_ff  <= kslwl_pkg::TICK_W'(kslwl_pkg::BLINK_ON_RESET);
         blink_off_ff <= kslwl_pkg::TICK_W'(kslwl_pkg::BLINK_OFF_RESET);
         rounds_ff    <= kslwl_pkg::ROUNDS_W'(kslwl_pkg::ROUNDS_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            kslwl_pkg::CSR_CODE: begin
               code_ff <= csr_wr_data[CODE_W-1:0];
            end
            kslwl_pkg::CSR_LOCKOUT: begin
               lockout_ff <= csr_wr_data[kslwl_pkg::TICK_W-1:0];
            end
            kslwl_pkg::CSR_BLINK_ON: begin
               blink_on_ff <= csr_wr_data[kslwl_pkg::TICK_W-1:0];
            end
            kslwl_pkg::CSR_BLINK_OFF: begin
               blink_off_ff <= csr_wr_data[kslwl_pkg::TICK_W-1:0];
            end
            kslwl_pkg::CSR_ROUNDS: begin
               rounds_ff <= csr_wr_data[kslwl_pkg::ROUNDS_W-1:0];
            end
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   // ---- request register and flow control ----
   logic                req_valid_ff, req_valid_in;
   logic [NUM_KEYS-1:0] req_mask_ff;
   logic                req_take;
   logic                advance;   // response register can load
   logic                step;      // one tick is processed this cycle
   logic                rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (step) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_mask_ff <= req_key_pressed_mask;
      end
   end

   // ---- tick processing ----
   logic [PHASE_W-1:0]         phase_in;
   kslwl_pkg::lock_status_type status;
   logic                       level_in;

   kslwl_code_fsm #(
      .NUM_KEYS    (NUM_KEYS),
      .CODE_LENGTH (CODE_LENGTH)
   ) u_code_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .key_mask      (req_mask_ff),
      .code_seq      (code_ff),
      .lockout_ticks (lockout_ff),
      .phase_in      (phase_in),
      .status        (status)
   );

   kslwl_blink u_blink (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .status    (status),
      .on_ticks  (blink_on_ff),
      .off_ticks (blink_off_ff),
      .rounds    (rounds_ff),
      .level_in  (level_in)
   );

   // ---- response register ----
   logic               rsp_unlock_ff;
   logic               rsp_error_ff;
   logic               rsp_success_ff;
   logic [PHASE_W-1:0] rsp_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_unlock_ff  <= status.unlock;
         rsp_error_ff   <= status.lockout;
         rsp_success_ff <= level_in;
         rsp_phase_ff   <= phase_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_unlock_pulse      = rsp_unlock_ff;
   assign rsp_error_indicator   = rsp_error_ff;
   assign rsp_success_indicator = rsp_success_ff;
   assign rsp_lock_phase        = rsp_phase_ff;

   // ---- assertions ----
   // a held response is never overwritten by a new tick
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(step && rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   // an unlock leaves the sequencer idle with the light on
   a_unlock_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unlock_ff) |-> (rsp_phase_ff == PH_IDLE) && rsp_success_ff)
      else $error("unlock response with wrong phase or light");

   // phase never goes past lockout, and lockout implies the error light
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_phase_ff <= PH_LOCKOUT) &&
                       (rsp_error_ff == (rsp_phase_ff == PH_LOCKOUT)))
      else $error("phase out of range or error flag mismatch");

endmodule

`default_nettype wire

/* bench/key_sequence_lock_with_lockout_test.sv */
// Self-checking bench for the keypad combination lock with lockout.
// Depends on kslwl_pkg and key_sequence_lock_with_lockout; a table of requests,
// then random key sequences, checked against the table or an in-bench lock predictor.
`timescale 1ns / 100ps

module key_sequence_lock_with_lockout_test;

   // lock phases as reported on rsp_lock_phase
   localparam logic [2:0] PH_START   = 3'd0;  // no key matched yet
   localparam logic [2:0] LAST_POS   = 3'd3;  // waiting for the final key
   localparam logic [2:0] PH_DISCARD = 3'd4;  // swallowing the rest of a bad code
   localparam logic [2:0] PH_LOCKOUT = 3'd5;

   localparam int IDLE_PCT       = 7;     // chance of an idle cycle on either side
   localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
   localparam int HOLD_SPACING   = 700;   // responses between hold-offs
   localparam int DRAIN_PAD      = 6;     // settling margin after the last response
   localparam int REPORT_LIMIT   = 10;
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all

   typedef struct packed {
      logic       unlock;
      logic       lockout;
      logic       light;
      logic [2:0] phase;
   } lock_outputs_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [kslwl_pkg::CSR_IDX_W-1:0] index;
      logic [15:0]                     data;
      logic [3:0]                      keys;
      logic                            typed;  // want is read straight from the row
      lock_outputs_type                want;
   } bench_row_type;

   // Directed requests. Starts on the reset code (keys 0, 2, 1, 3, lockout 1000,
   // blink 50/50 x4), then switches to code 3,3,3,3 with zero lengths.
   localparam bench_row_type DIRECTED [38] = '{
      '{ROW_TICK, '0, '0, 4'h0, 1'b1, '{1'b0, 1'b0, 1'b0, 3'd0}},  // quiet tick
      '{ROW_TICK, '0, '0, 4'h1, 1'b1, '{1'b0, 1'b0, 1'b0, 3'd1}},
      '{ROW_TICK, '0, '0, 4'h4, 1'b1, '{1'b0, 1'b0, 1'b0, 3'd2}},
      '{ROW_TICK, '0, '0, 4'h2, 1'b1, '{1'b0, 1'b0, 1'b0, 3'd3}},
      '{ROW_TICK, '0, '0, 4'h8, 1'b1, '{1'b1, 1'b0, 1'b1, 3'd0}},  // unlock
      '{ROW_TICK, '0, '0, 4'hF, 1'b1, '{1'b0, 1'b0, 1'b1, 3'd1}},  // all keys at once
      '{ROW_TICK, '0, '0, 4'h1, 1'b1, '{1'b0, 1'b0, 1'b1, PH_DISCARD}},
      '{ROW_TICK, '0, '0, 4'hB, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h2, 1'b1, '{1'b0, 1'b1, 1'b1, PH_LOCKOUT}},
      '{ROW_TICK, '0, '0, 4'hF, 1'b1, '{1'b0, 1'b1, 1'b1, PH_LOCKOUT}},  // ignored
      '{ROW_CSR, kslwl_pkg::CSR_LOCKOUT, 16'd0, '0, 1'b0, '0},
      '{ROW_CSR, kslwl_pkg::CSR_CODE, 16'h00FF, '0, 1'b0, '0},
      '{ROW_CSR, kslwl_pkg::CSR_BLINK_ON, 16'd0, '0, 1'b0, '0},
      '{ROW_CSR, kslwl_pkg::CSR_BLINK_OFF, 16'd0, '0, 1'b0, '0},
      '{ROW_CSR, kslwl_pkg::CSR_ROUNDS, 16'd1, '0, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},  // lockout ends, press ignored
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b1, '{1'b1, 1'b0, 1'b1, 3'd0}},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h7, 1'b1, '{1'b0, 1'b1, 1'b0, PH_LOCKOUT}},  // bad last key
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_CSR, kslwl_pkg::CSR_ROUNDS, 16'd0, '0, 1'b0, '0},  // wraps to sixteen rounds
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b1, '{1'b1, 1'b0, 1'b1, 3'd0}},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h8, 1'b1, '{1'b1, 1'b0, 1'b1, 3'd0}},  // restarts blink
      '{ROW_TICK, '0, '0, 4'h0, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h0, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h0, 1'b0, '0},
      '{ROW_TICK, '0, '0, 4'h0, 1'b0, '0}
   };

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [3:0]                      req_key_pressed_mask;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_unlock_pulse;
   logic                            rsp_error_indicator;
   logic                            rsp_success_indicator;
   logic [2:0]                      rsp_lock_phase;
   logic                            csr_wr_en;
   logic [kslwl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0]                     csr_wr_data;

   key_sequence_lock_with_lockout dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_key_pressed_mask  (req_key_pressed_mask),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_unlock_pulse      (rsp_unlock_pulse),
      .rsp_error_indicator   (rsp_error_indicator),
      .rsp_success_indicator (rsp_success_indicator),
      .rsp_lock_phase        (rsp_lock_phase),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data)
   );

   // Register copies, kept in step with every CSR write.
   logic [7:0]  code_keys   = 8'(kslwl_pkg::CODE_RESET);
   logic [15:0] lockout_len = 16'(kslwl_pkg::LOCKOUT_RESET);
   logic [15:0] on_len      = 16'(kslwl_pkg::BLINK_ON_RESET);
   logic [15:0] off_len     = 16'(kslwl_pkg::BLINK_OFF_RESET);
   logic [3:0]  round_total = 4'(kslwl_pkg::ROUNDS_RESET);

   // Predicted lock state; all zero out of reset.
   logic [2:0]  lock_pos     = PH_START;
   logic [1:0]  swallow_left = '0;
   logic [15:0] lockout_age  = '0;
   logic        blinking     = 1'b0;
   logic [3:0]  rounds_to_go = '0;
   logic [15:0] blink_age    = '0;
   logic        light_on     = 1'b0;

   lock_outputs_type outputs_due [$];   // expected responses, oldest first
   lock_outputs_type seen_outputs;
   lock_outputs_type due_outputs;
   lock_outputs_type forecast;

   // Typed expectation for the request currently offered (directed rows only).
   logic             fixed_due = 1'b0;
   lock_outputs_type fixed_result = '0;

   int  mismatches   = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   int  sent_ticks   = 0;   // random requests offered
   int  hold_left    = 0;
   int  next_hold_at = 200;
   bit  calm         = 1'b0; // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void enter_lockout();
      lock_pos     = PH_LOCKOUT;
      lockout_age  = '0;
      swallow_left = '0;
   endfunction

   // One tick of the lock: moves the predicted state on and returns its outputs.
   function automatic lock_outputs_type advance_lock(input logic [3:0] keys);
      lock_outputs_type o;
      logic [1:0]       want_key;
      logic             restarted;
      logic [15:0]      span;
      o         = '0;
      restarted = 1'b0;
      want_key  = code_keys[{lock_pos[1:0], 1'b0} +: 2];
      if (lock_pos < PH_DISCARD) begin
         if (keys != 4'h0) begin
            // extra keys held alongside the right one do no harm
            if (keys[want_key]) begin
               if (lock_pos == LAST_POS) begin
                  o.unlock     = 1'b1;
                  lock_pos     = PH_START;
                  blinking     = 1'b1;
                  rounds_to_go = round_total;
                  blink_age    = '0;
                  light_on     = 1'b1;
                  restarted    = 1'b1;
               end else begin
                  lock_pos = lock_pos + 3'd1;
               end
            end else if (lock_pos == LAST_POS) begin
               enter_lockout();
            end else begin
               swallow_left = 2'd3 - lock_pos[1:0];
               lock_pos     = PH_DISCARD;
            end
         end
      end else if (lock_pos == PH_DISCARD) begin
         if (keys != 4'h0) begin
            if (swallow_left <= 2'd1)
               enter_lockout();
            else
               swallow_left = swallow_left - 2'd1;
         end
      end else if (lock_pos == PH_LOCKOUT) begin
         if (lockout_age >= lockout_len)
            lock_pos = PH_START;
         else
            lockout_age = lockout_age + 16'd1;
      end else begin
         lock_pos = PH_START;
      end

      // blink lengths are taken live from the registers
      if (blinking && !restarted) begin
         span = light_on ? on_len : off_len;
         if (blink_age >= span) begin
            blink_age = '0;
            if (light_on) begin
               light_on = 1'b0;
            end else if (rounds_to_go == 4'd1) begin
               blinking     = 1'b0;
               rounds_to_go = '0;
            end else begin
               rounds_to_go = rounds_to_go - 4'd1;  // zero wraps: sixteen rounds
               light_on     = 1'b1;
            end
         end else begin
            blink_age = blink_age + 16'd1;
         end
      end

      o.lockout = (lock_pos == PH_LOCKOUT);
      o.light   = light_on;
      o.phase   = lock_pos;
      return o;
   endfunction

   function automatic void note_fault(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s", $time, what);
   endfunction

   // Monitor: responses are checked before the request of the same edge is
   // predicted, so the order of the two within a step never matters.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            results_seen++;
            seen_outputs = '{rsp_unlock_pulse, rsp_error_indicator,
                             rsp_success_indicator, rsp_lock_phase};
            if (outputs_due.size() == 0) begin
               note_fault($sformatf("response with none due: unlock %b err %b light %b ph %0d",
                  seen_outputs.unlock, seen_outputs.lockout, seen_outputs.light,
                  seen_outputs.phase));
            end else begin
               due_outputs = outputs_due.pop_front();
               if (seen_outputs.unlock !== due_outputs.unlock
                     || seen_outputs.lockout !== due_outputs.lockout
                     || seen_outputs.light !== due_outputs.light
                     || seen_outputs.phase !== due_outputs.phase)
                  note_fault($sformatf({"response mismatch: unlock %b/%b err %b/%b ",
                     "light %b/%b phase %0d/%0d (got/expected)"},
                     seen_outputs.unlock, due_outputs.unlock,
                     seen_outputs.lockout, due_outputs.lockout,
                     seen_outputs.light, due_outputs.light,
                     seen_outputs.phase, due_outputs.phase));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            // the predictor always runs so its state stays in step
            forecast = advance_lock(req_key_pressed_mask);
            outputs_due.push_back(fixed_due ? fixed_result : forecast);
         end
         // watchdog: any handshake counts as progress
         if ((req_valid === 1'b1 && req_stall === 1'b0)
               || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   // Response side: random stalls, plus a long hold-off now and then so that
   // the block fills and pushes back on the request side.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Offers one request from a falling edge and returns at the falling edge
   // after it was taken. Valid is assigned once per step.
   task automatic send_request(input logic [3:0] keys, input logic typed,
                               input lock_outputs_type want);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      fixed_due    = typed;
      fixed_result = want;
      req_valid            <= 1'b1;
      req_key_pressed_mask <= keys;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [3:0] keys);
      sent_ticks++;
      send_request(keys, 1'b0, '0);
   endtask

   // Lets every outstanding response come back, then a little more.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outputs_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   // Leaves csr_wr_en high; the caller lowers it after the last write.
   task automatic write_csr(input logic [kslwl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         kslwl_pkg::CSR_CODE:      code_keys   = value[7:0];
         kslwl_pkg::CSR_LOCKOUT:   lockout_len = value;
         kslwl_pkg::CSR_BLINK_ON:  on_len      = value;
         kslwl_pkg::CSR_BLINK_OFF: off_len     = value;
         kslwl_pkg::CSR_ROUNDS:    round_total = value[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] code, input logic [15:0] lockout,
                                 input logic [15:0] on_ticks, input logic [15:0] off_ticks,
                                 input logic [3:0] rounds);
      wait_idle();
      write_csr(kslwl_pkg::CSR_CODE, {8'h00, code});
      write_csr(kslwl_pkg::CSR_LOCKOUT, lockout);
      write_csr(kslwl_pkg::CSR_BLINK_ON, on_ticks);
      write_csr(kslwl_pkg::CSR_BLINK_OFF, off_ticks);
      write_csr(kslwl_pkg::CSR_ROUNDS, {12'h000, rounds});
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [1:0] next_key();
      return code_keys[{lock_pos[1:0], 1'b0} +: 2];
   endfunction

   // Idles (with stray presses) until the lock takes keys again.
   task automatic wait_ready();
      while (lock_pos >= PH_DISCARD)
         send_tick(($urandom_range(3) == 0) ? 4'($urandom_range(1, 15)) : 4'h0);
   endtask

   // Next right key, sometimes after quiet ticks, sometimes with other keys.
   task automatic press_right();
      logic [3:0] keys;
      keys = 4'h1 << next_key();
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) send_tick(4'h0);
      if ($urandom_range(2) == 0)
         keys = keys | 4'($urandom);
      send_tick(keys);
   endtask

   task automatic press_wrong();
      logic [3:0] keys;
      keys = 4'($urandom_range(1, 15)) & ~(4'h1 << next_key());
      if (keys == 4'h0)
         keys = ~(4'h1 << next_key());
      send_tick(keys);
   endtask

   // Mostly well-formed codes, some broken ones, and some plain noise.
   task automatic run_random(input int count);
      int start;
      int pick;
      start = sent_ticks;
      while (sent_ticks - start < count) begin
         wait_ready();
         pick = $urandom_range(9);
         if (pick < 5) begin
            repeat (4 - lock_pos) press_right();
         end else if (pick < 8) begin
            repeat ($urandom_range(0, 3 - lock_pos)) press_right();
            press_wrong();
            repeat ($urandom_range(4)) send_tick(4'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) send_tick(4'($urandom));
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_key_pressed_mask = 4'h0;
      csr_wr_en            = 1'b0;
      csr_index            = kslwl_pkg::CSR_CODE;
      csr_wr_data          = 16'h0000;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed table; CSR rows only ever follow a drained block
      for (int r = 0; r < $size(DIRECTED); r++) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            if (r == 0 || DIRECTED[r-1].kind != ROW_CSR)
               wait_idle();
            write_csr(DIRECTED[r].index, DIRECTED[r].data);
         end else begin
            csr_wr_en <= 1'b0;
            send_request(DIRECTED[r].keys, DIRECTED[r].typed, DIRECTED[r].want);
         end
      end

      // short random lengths, a few rounds
      apply_settings(8'($urandom), 16'($urandom_range(30)), 16'($urandom_range(6)),
                     16'($urandom_range(6)), 4'($urandom_range(1, 4)));
      run_random(250);

      // all-zero code, zero rounds, and a stretch with no idling at all
      apply_settings(8'h00, 16'd1, 16'd1, 16'd2, 4'd0);
      calm = 1'b1;
      run_random(200);
      calm = 1'b0;

      // all-ones code, zero lengths, most rounds
      apply_settings(8'hFF, 16'd0, 16'd0, 16'd0, 4'd15);
      run_random(200);

      // anything goes, within modest lengths
      apply_settings(8'($urandom), 16'($urandom_range(40)), 16'($urandom_range(20)),
                     16'($urandom_range(20)), 4'($urandom_range(15)));
      run_random(250);

      // longest lockout and on phase: unlock, fail the code and sit in the
      // lockout with stray presses, then shorten the lockout below the time
      // already spent so that it ends on the next tick, and open again
      apply_settings(8'($urandom), 16'hFFFF, 16'hFFFF, 16'd0, 4'd2);
      repeat (4) press_right();
      repeat (3) press_right();
      press_wrong();
      repeat (150) send_tick(($urandom_range(15) == 0) ? 4'($urandom) : 4'h0);
      apply_settings(code_keys, 16'd100, 16'hFFFF, 16'd0, 4'd2);
      wait_ready();
      repeat (4 - lock_pos) press_right();

      apply_settings(8'($urandom), 16'($urandom_range(10)), 16'($urandom_range(3)),
                     16'($urandom_range(3)), 4'($urandom_range(1, 15)));
      run_random(150);

      wait_idle();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
